### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the tag nesting checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/tnc_pkg.sv
// Package with beat types, verdict codes and character constants of the tag nesting checker.
`default_nettype none

package tnc_pkg;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_MISMATCH  = 2'd1,
    VERDICT_EMPTY_POP = 2'd2
  } verdict_e;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] POS_MAX    = 8'hFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_document;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [6:0] open_depth;
    logic       push_dropped;
  } out_beat_t;

  typedef struct packed {
    logic      emit;
    out_beat_t result;
  } eng_status_t;

endpackage

`default_nettype wire

### hw/rtl/tnc_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module tnc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/tnc_engine.sv
// Tag parsing state, name stack memories with forwarding, and per-byte check logic.
`default_nettype none

module tnc_engine #(
  parameter int STACK_DEPTH = 64,
  parameter int TAG_BYTES   = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire tnc_pkg::in_beat_t beat_i,
  output tnc_pkg::eng_status_t   status_o
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int KW = $clog2(TAG_BYTES);
  localparam int LW = $clog2(TAG_BYTES + 1);
  localparam int NAME_WORDS = STACK_DEPTH * TAG_BYTES;
  localparam int AW = $clog2(NAME_WORDS);
  localparam logic [7:0]    TAG_B8  = 8'(TAG_BYTES);
  localparam logic [AW-1:0] TAG_A   = AW'(TAG_BYTES);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic          inside_q, inside_d, inside_s;
  logic [7:0]    pos_q, pos_d, pos_s;
  logic          closing_q, closing_d, closing_s;
  logic          ended_q, ended_d, ended_s;
  logic          failed_q, failed_d, failed_s;
  logic [7:0]    prev_q, prev_d, prev_s;
  logic          ovf_q, ovf_d, ovf_s;
  logic          err_q, err_d;
  logic [LW-1:0] clen_q, clen_d, clen_s;
  logic [CW-1:0] count_q, count_d, count_s;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_rdata, name_byte;
  logic          st_hit_q;
  logic [7:0]    st_fwd_q;
  logic          ln_we;
  logic [SW-1:0] ln_waddr, rd_slot;
  logic [LW-1:0] ln_wdata, ln_rdata, len_top;
  logic          ln_hit_q;
  logic [LW-1:0] ln_fwd_q;
  logic [KW-1:0] rd_off;

  logic [7:0]    b;
  logic          last;
  logic          do_fin;
  logic [7:0]    k;
  logic [7:0]    rest;
  logic [7:0]    used;
  logic [7:0]    pos_m1_d;
  tnc_pkg::verdict_e verdict;

  assign b    = beat_i.text_byte;
  assign last = beat_i.end_of_document;

  assign name_byte = st_hit_q ? st_fwd_q : st_rdata;
  assign len_top   = ln_hit_q ? ln_fwd_q : ln_rdata;

  always_comb begin
    inside_s  = inside_q;
    pos_s     = pos_q;
    closing_s = closing_q;
    ended_s   = ended_q;
    failed_s  = failed_q;
    prev_s    = prev_q;
    ovf_s     = ovf_q;
    clen_s    = clen_q;
    count_s   = count_q;
    st_we     = 1'b0;
    st_waddr  = AW'(count_q[SW-1:0]) * TAG_A + AW'(pos_q[KW-1:0]);
    ln_we     = 1'b0;
    ln_waddr  = count_q[SW-1:0];
    ln_wdata  = clen_q;
    verdict   = tnc_pkg::VERDICT_OK;
    k         = pos_q - 8'd1;
    rest      = 8'd0;
    used      = 8'd0;

    if (!err_q) begin
      if (inside_q) begin
        if (b != tnc_pkg::CHAR_GT) begin
          if (pos_q == 8'd0 && b == tnc_pkg::CHAR_SLASH) begin
            closing_s = 1'b1;
          end else if (closing_q) begin
            if (k < TAG_B8 && count_q != '0) begin
              if (k >= 8'(len_top) || name_byte != b) begin
                failed_s = 1'b1;
              end
            end
          end else if (!ended_q) begin
            if (b == tnc_pkg::CHAR_SPACE) begin
              ended_s = 1'b1;
            end else if (pos_q < TAG_B8 && count_q < DEPTH_C) begin
              st_we  = 1'b1;
              clen_s = LW'({1'b0, pos_q} + 9'd1);
            end
          end
          prev_s = b;
          if (pos_q != tnc_pkg::POS_MAX) begin
            pos_s = pos_q + 8'd1;
          end
        end
      end else if (b == tnc_pkg::CHAR_LT) begin
        inside_s  = 1'b1;
        pos_s     = 8'd0;
        closing_s = 1'b0;
        ended_s   = 1'b0;
        failed_s  = 1'b0;
        prev_s    = 8'd0;
        clen_s    = '0;
      end
    end

    do_fin = !err_q && inside_s && ((inside_q && b == tnc_pkg::CHAR_GT) || last);
    if (do_fin) begin
      inside_s = 1'b0;
      if (pos_s != 8'd0) begin
        if (closing_s) begin
          if (count_q == '0) begin
            verdict = tnc_pkg::VERDICT_EMPTY_POP;
          end else begin
            rest = pos_s - 8'd1;
            used = (rest < TAG_B8) ? rest : TAG_B8;
            if (used < 8'(len_top)) begin
              failed_s = 1'b1;
            end
            count_s = count_q - CW'(1);
            verdict = failed_s ? tnc_pkg::VERDICT_MISMATCH : tnc_pkg::VERDICT_OK;
          end
        end else if (prev_s != tnc_pkg::CHAR_SLASH) begin
          if (count_q >= DEPTH_C) begin
            ovf_s = 1'b1;
          end else begin
            ln_we    = 1'b1;
            ln_wdata = clen_s;
            count_s  = count_q + CW'(1);
          end
        end
      end
    end

    st_we = st_we && fire_i;
    ln_we = ln_we && fire_i;

    status_o.emit                = !err_q && (verdict != tnc_pkg::VERDICT_OK || last);
    status_o.result.verdict      = verdict;
    status_o.result.open_depth   = 7'(count_s);
    status_o.result.push_dropped = ovf_s;
  end

  always_comb begin
    inside_d  = inside_q;
    pos_d     = pos_q;
    closing_d = closing_q;
    ended_d   = ended_q;
    failed_d  = failed_q;
    prev_d    = prev_q;
    ovf_d     = ovf_q;
    err_d     = err_q;
    clen_d    = clen_q;
    count_d   = count_q;
    if (fire_i) begin
      if (last) begin
        inside_d  = 1'b0;
        pos_d     = 8'd0;
        closing_d = 1'b0;
        ended_d   = 1'b0;
        failed_d  = 1'b0;
        prev_d    = 8'd0;
        ovf_d     = 1'b0;
        err_d     = 1'b0;
        clen_d    = '0;
        count_d   = '0;
      end else if (!err_q) begin
        inside_d  = inside_s;
        pos_d     = pos_s;
        closing_d = closing_s;
        ended_d   = ended_s;
        failed_d  = failed_s;
        prev_d    = prev_s;
        ovf_d     = ovf_s;
        err_d     = (verdict != tnc_pkg::VERDICT_OK);
        clen_d    = clen_s;
        count_d   = count_s;
      end
    end
  end

  // The memories are read every cycle at the top-of-stack entry that the next byte will use.
  always_comb begin
    pos_m1_d = pos_d - 8'd1;
    rd_slot  = (count_d == '0) ? '0 : SW'(count_d - CW'(1));
    rd_off   = (pos_d == 8'd0 || pos_m1_d >= TAG_B8) ? '0 : pos_m1_d[KW-1:0];
    st_raddr = AW'(rd_slot) * TAG_A + AW'(rd_off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      pos_q     <= 8'd0;
      closing_q <= 1'b0;
      ended_q   <= 1'b0;
      failed_q  <= 1'b0;
      prev_q    <= 8'd0;
      ovf_q     <= 1'b0;
      err_q     <= 1'b0;
      clen_q    <= '0;
      count_q   <= '0;
      st_hit_q  <= 1'b0;
      ln_hit_q  <= 1'b0;
    end else begin
      inside_q  <= inside_d;
      pos_q     <= pos_d;
      closing_q <= closing_d;
      ended_q   <= ended_d;
      failed_q  <= failed_d;
      prev_q    <= prev_d;
      ovf_q     <= ovf_d;
      err_q     <= err_d;
      clen_q    <= clen_d;
      count_q   <= count_d;
      st_hit_q  <= st_we && (st_waddr == st_raddr);
      ln_hit_q  <= ln_we && (ln_waddr == rd_slot);
    end
  end

  always_ff @(posedge clk_i) begin
    st_fwd_q <= b;
    ln_fwd_q <= ln_wdata;
  end

  tnc_ram #(
    .DEPTH (NAME_WORDS),
    .WIDTH (8)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (b),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  tnc_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (LW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .raddr_i (rd_slot),
    .rdata_o (ln_rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/tag_nesting_checker_top.sv
// Top level of the tag nesting checker: input register, check engine and result register.
// The block takes one document byte per cycle when not stalled. A verdict beat is computed from
// the byte in the input register and presented from the output register. As a byte is accepted
// into the input register, the name and length memories are read at the top of stack that the
// byte will use, and the byte is checked against that read data while it sits in the register,
// which the registered memory read allows. Bytes that produce no verdict never wait on the
// output; a verdict beat waits in the output register, and only a further verdict stalls behind
// it. A verdict is given on the first nesting error, or on the last byte of a document without
// one; that last byte returns the check state to reset. No clearing pass runs after reset.
`default_nettype none
`include "assert_macros.svh"

module tag_nesting_checker_top #(
  parameter int STACK_DEPTH = 64,
  parameter int TAG_BYTES   = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire tnc_pkg::in_beat_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      tnc_pkg::out_beat_t out_data_o
);

  logic                 valid_q, valid_d;
  tnc_pkg::in_beat_t    beat_q;
  logic                 out_valid_q, out_valid_d;
  tnc_pkg::out_beat_t   out_q;
  tnc_pkg::eng_status_t st;
  logic                 fire;
  logic                 in_acc;

  assign fire       = valid_q && !(st.emit && out_valid_q && !out_ready_i);
  assign in_ready_o = !valid_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_acc) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire && st.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      beat_q <= in_data_i;
    end
    if (fire && st.emit) begin
      out_q <= st.result;
    end
  end

  tnc_engine #(
    .STACK_DEPTH (STACK_DEPTH),
    .TAG_BYTES   (TAG_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (beat_q),
    .status_o (st)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_verdict_only_on_error_or_end, fire && st.emit, st.result.verdict != tnc_pkg::VERDICT_OK || beat_q.end_of_document)
  `ASSERT_IMPL(a_empty_pop_leaves_no_depth, out_valid_o && out_data_o.verdict == tnc_pkg::VERDICT_EMPTY_POP, out_data_o.open_depth == 7'd0)
  `ASSERT_NEXT(a_held_byte_kept, valid_q && !fire, valid_q && $stable(beat_q))

endmodule

`default_nettype wire
